@@ rtl/mfd_pkg.sv @@
`default_nettype none
package mfd_pkg;

    localparam logic [7:0] MARK_V1      = 8'hFE;
    localparam logic [7:0] MARK_V2      = 8'hFD;
    localparam logic [8:0] OVERHEAD_V1  = 9'd8;
    localparam logic [8:0] OVERHEAD_V2  = 9'd12;
    localparam logic [8:0] SIGNED_EXTRA = 9'd13;
    localparam logic [8:0] HEADER_V1    = 9'd2;
    localparam logic [8:0] HEADER_V2    = 9'd3;
    localparam logic [8:0] DEFAULT_MAX_LEN = 9'd250;

    localparam int OUT_SLOTS   = 6;
    localparam int CNT_W       = $clog2(OUT_SLOTS + 1);
    localparam int MAX_PUSH    = 3;

    typedef logic [CNT_W-1:0] t_count;

    typedef enum logic [1:0] {
        REG_MAX_FRAME_LEN = 2'd0,
        REG_ACCEPT_V2     = 2'd1
    } t_reg_index;

    typedef enum logic [3:0] {
        PH_HUNT  = 4'b0001,
        PH_LEN   = 4'b0010,
        PH_FLAGS = 4'b0100,
        PH_BODY  = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_first;
        logic       frame_last;
        logic       frame_version;
    } t_entry;

endpackage
`default_nettype wire

@@ rtl/mavlink_frame_delimiter.sv @@
// Byte-stream frame delimiter for a telemetry link, one byte per transaction.
// Bytes are dropped until a start marker (0xFE version 1, 0xFD version 2 when
// accept_v2 is set) arrives; the header bytes are held until the frame length
// is known, then the whole frame is passed out byte by byte with first/last
// marks, or skipped when longer than max_frame_len. The block takes one input
// byte per clock while o_stall is low: the phase machine and length counter
// decide each byte combinationally, and results go into a six-entry output
// queue that hands out one byte per clock while i_stall is low. The length or
// flags byte releases a burst of two or three held header bytes at once; input
// stall rises only while more than three results are queued, so a steady stream
// with a draining output runs at one byte per cycle via the registered queue.
`default_nettype none
module mavlink_frame_delimiter
    import mfd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,

    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_data_byte,

    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [7:0]      o_out_byte,
    output logic            o_frame_first,
    output logic            o_frame_last,
    output logic            o_frame_version,

    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [1:0] i_cfg_index,
    input  wire logic [8:0] i_cfg_data
);

    logic [8:0] r_max_frame_len;
    logic       r_accept_v2;

    t_phase     r_phase, n_phase;
    logic [7:0] r_held_marker, n_held_marker;
    logic [7:0] r_held_length, n_held_length;
    logic [8:0] r_bytes_left, n_bytes_left;
    logic       r_is_v2, n_is_v2;
    logic       r_dropping, n_dropping;

    t_entry     r_q [OUT_SLOTS];
    t_entry     n_q [OUT_SLOTS];
    t_count     r_count, n_count;

    logic       accept;
    logic       pop;
    logic [1:0] push;
    t_entry     e0, e1, e2;
    logic [8:0] total_v1, total_v2, left_dec;
    t_count     base;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = (r_count > t_count'(OUT_SLOTS - MAX_PUSH));
    assign accept      = i_valid && !o_stall;
    assign o_valid     = (r_count != '0);
    assign pop         = o_valid && !i_stall;

    assign o_out_byte      = r_q[0].out_byte;
    assign o_frame_first   = r_q[0].frame_first;
    assign o_frame_last    = r_q[0].frame_last;
    assign o_frame_version = r_q[0].frame_version;

    assign total_v1 = {1'b0, i_data_byte} + OVERHEAD_V1;
    assign total_v2 = {1'b0, r_held_length} + OVERHEAD_V2
                    + (i_data_byte[0] ? SIGNED_EXTRA : 9'd0);
    assign left_dec = (r_bytes_left != '0) ? r_bytes_left - 9'd1 : r_bytes_left;

    always_comb begin
        n_phase       = r_phase;
        n_held_marker = r_held_marker;
        n_held_length = r_held_length;
        n_bytes_left  = r_bytes_left;
        n_is_v2       = r_is_v2;
        n_dropping    = r_dropping;
        push          = 2'd0;
        e0 = '{out_byte: r_held_marker, frame_first: 1'b1, frame_last: 1'b0,
               frame_version: r_is_v2};
        e1 = '{out_byte: r_held_length, frame_first: 1'b0, frame_last: 1'b0,
               frame_version: r_is_v2};
        e2 = '{out_byte: i_data_byte, frame_first: 1'b0, frame_last: 1'b0,
               frame_version: r_is_v2};
        if (accept) begin
            case (r_phase)
                PH_LEN: begin
                    n_held_length = i_data_byte;
                    if (!r_is_v2) begin
                        n_dropping   = (total_v1 > r_max_frame_len);
                        n_bytes_left = total_v1 - HEADER_V1;
                        n_phase      = PH_BODY;
                        e1.out_byte  = i_data_byte;
                        if (total_v1 <= r_max_frame_len) begin
                            push = 2'd2;
                        end
                    end else begin
                        n_phase = PH_FLAGS;
                    end
                end
                PH_FLAGS: begin
                    n_dropping   = (total_v2 > r_max_frame_len);
                    n_bytes_left = total_v2 - HEADER_V2;
                    n_phase      = PH_BODY;
                    if (total_v2 <= r_max_frame_len) begin
                        push = 2'd3;
                    end
                end
                PH_BODY: begin
                    n_bytes_left   = left_dec;
                    e0.out_byte    = i_data_byte;
                    e0.frame_first = 1'b0;
                    if (left_dec == '0) begin
                        n_phase       = PH_HUNT;
                        n_dropping    = 1'b0;
                        e0.frame_last = 1'b1;
                    end
                    if (!r_dropping) begin
                        push = 2'd1;
                    end
                end
                default: begin
                    if (i_data_byte == MARK_V1 || (i_data_byte == MARK_V2 && r_accept_v2)) begin
                        n_held_marker = i_data_byte;
                        n_is_v2       = (i_data_byte == MARK_V2);
                        n_dropping    = 1'b0;
                        n_phase       = PH_LEN;
                    end else begin
                        n_phase = PH_HUNT;
                    end
                end
            endcase
        end
    end

    always_comb begin
        base    = r_count - t_count'(pop);
        n_count = base + t_count'(push);
        for (int j = 0; j < OUT_SLOTS; j++) begin
            if (pop && j < OUT_SLOTS - 1) begin
                n_q[j] = r_q[(j + 1) % OUT_SLOTS];
            end else begin
                n_q[j] = r_q[j];
            end
            if (push >= 2'd1 && t_count'(j) == base) begin
                n_q[j] = e0;
            end
            if (push >= 2'd2 && t_count'(j) == t_count'(base + t_count'(1))) begin
                n_q[j] = e1;
            end
            if (push == 2'd3 && t_count'(j) == t_count'(base + t_count'(2))) begin
                n_q[j] = e2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_frame_len <= DEFAULT_MAX_LEN;
            r_accept_v2     <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_MAX_FRAME_LEN: r_max_frame_len <= i_cfg_data;
                REG_ACCEPT_V2:     r_accept_v2     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_HUNT;
            r_held_marker <= '0;
            r_held_length <= '0;
            r_bytes_left  <= '0;
            r_is_v2       <= 1'b0;
            r_dropping    <= 1'b0;
            r_count       <= '0;
        end else begin
            r_phase       <= n_phase;
            r_held_marker <= n_held_marker;
            r_held_length <= n_held_length;
            r_bytes_left  <= n_bytes_left;
            r_is_v2       <= n_is_v2;
            r_dropping    <= n_dropping;
            r_count       <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= t_count'(OUT_SLOTS))
        else $error("output queue overflow");

    a_body_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_BODY |-> r_bytes_left != '0)
        else $error("body phase with no bytes left");

    a_first_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_frame_first) |-> (o_out_byte == MARK_V1 || o_out_byte == MARK_V2))
        else $error("first byte is not a start marker");

    a_first_version: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_frame_first) |-> (o_frame_version == (o_out_byte == MARK_V2)))
        else $error("version mark disagrees with start marker");

endmodule
`default_nettype wire
